### src/lsod_pkg.sv
// ----------------------------------------------------------------------------
// Lens-shading OTP decoder package
// Shared types, constants and layout tables for the decoder core.
// ----------------------------------------------------------------------------
package lsod_pkg;

  localparam int unsigned RawDepth   = 189;
  localparam int unsigned TblDepth   = 360;
  localparam int unsigned PlaneLen   = 120;
  localparam int unsigned SumMod     = 255;
  localparam int unsigned RawSumLast = 185;
  localparam int unsigned AddrRawChk = 186;
  localparam int unsigned AddrTblChk = 187;
  localparam int unsigned AddrXorChk = 188;
  localparam int unsigned Chroma1Ofs = 86;
  localparam int unsigned Chroma2Ofs = 136;
  localparam int unsigned DeltaOfs   = 20;
  localparam int unsigned LumaSplit  = 48;
  localparam int unsigned LumaShift  = 16;
  localparam int unsigned NarrowMax  = 5;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_DECODE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [8:0] index;
    logic [7:0] raw_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] entry_value;
    logic       raw_sum_match;
    logic       table_sum_match;
    logic       table_valid;
  } out_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SWEEP = 9'b000000010,
    ST_F0    = 9'b000000100,
    ST_F1    = 9'b000001000,
    ST_F2    = 9'b000010000,
    ST_F3    = 9'b000100000,
    ST_WR    = 9'b001000000,
    ST_FIN   = 9'b010000000,
    ST_RD    = 9'b100000000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       raw_wr;
    logic       tbl_rd;
    logic       clr;
    logic       sweep_rd;
    logic [7:0] sweep_addr;
    logic       fetch_rd;
    logic [1:0] fetch_sel;
    logic       latch0;
    logic       latch1;
    logic       latch2;
    logic       wr;
    logic [1:0] plane;
    logic [6:0] ent;
    logic [6:0] lj;
    logic [3:0] row;
    logic [3:0] col;
    logic       fin;
    logic       out_rd;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic luma_lay1;
    logic chroma_lay1;
    logic out_valid;
  } dp_stat_t;

  // Luma interleave segments: start in the unpacked array and length.
  localparam logic [6:0] SegAStart [0:20] = '{
    7'd48, 7'd16, 7'd74, 7'd24, 7'd0, 7'd26, 7'd78, 7'd28, 7'd4, 7'd30, 7'd82,
    7'd32, 7'd8, 7'd34, 7'd86, 7'd36, 7'd12, 7'd38, 7'd90, 7'd40, 7'd94};
  localparam logic [4:0] SegALen [0:20] = '{
    5'd26, 5'd8, 5'd4, 5'd2, 5'd4, 5'd2, 5'd4, 5'd2, 5'd4, 5'd2, 5'd4,
    5'd2, 5'd4, 5'd2, 5'd4, 5'd2, 5'd4, 5'd2, 5'd4, 5'd8, 5'd26};
  localparam logic [6:0] SegBStart [0:24] = '{
    7'd48, 7'd16, 7'd70, 7'd22, 7'd74, 7'd28, 7'd0, 7'd29, 7'd78, 7'd30,
    7'd4, 7'd31, 7'd82, 7'd32, 7'd8, 7'd33, 7'd86, 7'd34, 7'd12, 7'd35,
    7'd90, 7'd36, 7'd94, 7'd42, 7'd98};
  localparam logic [4:0] SegBLen [0:24] = '{
    5'd22, 5'd6, 5'd4, 5'd6, 5'd4, 5'd1, 5'd4, 5'd1, 5'd4, 5'd1,
    5'd4, 5'd1, 5'd4, 5'd1, 5'd4, 5'd1, 5'd4, 5'd1, 5'd4, 5'd1,
    5'd4, 5'd6, 5'd4, 5'd6, 5'd22};

  function automatic logic [6:0] seg_start(input logic lay1, input logic [4:0] s);
    logic [6:0] r;
    r = '0;
    if (lay1) begin
      r = SegBStart[s];
    end else if (s < 5'd21) begin
      r = SegAStart[s];
    end
    return r;
  endfunction

  function automatic logic [4:0] seg_len(input logic lay1, input logic [4:0] s);
    logic [4:0] r;
    r = 5'd1;
    if (lay1) begin
      r = SegBLen[s];
    end else if (s < 5'd21) begin
      r = SegALen[s];
    end
    return r;
  endfunction

  // Running sum modulo 255; acc stays below 255.
  function automatic logic [7:0] mod255_add(input logic [7:0] acc, input logic [7:0] x);
    logic [8:0] s;
    s = {1'b0, acc} + {1'b0, x};
    if (s >= 9'(SumMod)) begin
      s = s - 9'(SumMod);
    end
    return s[7:0];
  endfunction

endpackage

### src/lsod_ctrl.sv
// ----------------------------------------------------------------------------
// Lens-shading OTP decoder controller
// Command sequencer and walk counters for sweep, expansion and readout.
// ----------------------------------------------------------------------------
module lsod_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         in_cmd_i,
  input  logic               out_stall_i,
  input  lsod_pkg::dp_stat_t stat_i,
  output lsod_pkg::ctrl_cmd_t cmd_o
);

  lsod_pkg::state_e st_q, st_d;
  logic [7:0] sweep_q, sweep_d;
  logic [1:0] plane_q, plane_d;
  logic [6:0] ent_q, ent_d;
  logic [4:0] seg_q, seg_d;
  logic [4:0] segi_q, segi_d;
  logic [3:0] row_q, row_d;
  logic [3:0] col_q, col_d;
  logic       accept;
  logic [4:0] segi_inc;
  logic [3:0] col_last;

  assign in_stall_o = (st_q != lsod_pkg::ST_IDLE) || (stat_i.out_valid && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign segi_inc   = segi_q + 5'd1;
  assign col_last   = stat_i.chroma_lay1 ? 4'd9 : 4'd11;

  always_comb begin
    st_d    = st_q;
    sweep_d = sweep_q;
    plane_d = plane_q;
    ent_d   = ent_q;
    seg_d   = seg_q;
    segi_d  = segi_q;
    row_d   = row_q;
    col_d   = col_q;
    cmd_o   = '0;
    cmd_o.sweep_addr = sweep_q;
    cmd_o.plane = plane_q;
    cmd_o.ent   = ent_q;
    cmd_o.lj    = lsod_pkg::seg_start(stat_i.luma_lay1, seg_q) + 7'(segi_q);
    cmd_o.row   = row_q;
    cmd_o.col   = col_q;
    case (st_q)
      lsod_pkg::ST_IDLE: begin
        if (accept) begin
          case (lsod_pkg::cmd_e'(in_cmd_i))
            lsod_pkg::CMD_LOAD: cmd_o.raw_wr = 1'b1;
            lsod_pkg::CMD_DECODE: begin
              cmd_o.clr = 1'b1;
              sweep_d   = '0;
              st_d      = lsod_pkg::ST_SWEEP;
            end
            lsod_pkg::CMD_READ: begin
              cmd_o.tbl_rd = 1'b1;
              st_d         = lsod_pkg::ST_RD;
            end
            default: ;
          endcase
        end
      end
      lsod_pkg::ST_SWEEP: begin
        cmd_o.sweep_rd = 1'b1;
        if (sweep_q == 8'(lsod_pkg::AddrXorChk)) begin
          plane_d = '0;
          ent_d   = '0;
          seg_d   = '0;
          segi_d  = '0;
          row_d   = '0;
          col_d   = '0;
          st_d    = lsod_pkg::ST_F0;
        end else begin
          sweep_d = sweep_q + 8'd1;
        end
      end
      lsod_pkg::ST_F0: begin
        cmd_o.fetch_rd  = 1'b1;
        cmd_o.fetch_sel = 2'd0;
        st_d = lsod_pkg::ST_F1;
      end
      lsod_pkg::ST_F1: begin
        cmd_o.fetch_rd  = 1'b1;
        cmd_o.fetch_sel = 2'd1;
        cmd_o.latch0    = 1'b1;
        st_d = lsod_pkg::ST_F2;
      end
      lsod_pkg::ST_F2: begin
        cmd_o.fetch_rd  = 1'b1;
        cmd_o.fetch_sel = 2'd2;
        cmd_o.latch1    = 1'b1;
        st_d = lsod_pkg::ST_F3;
      end
      lsod_pkg::ST_F3: begin
        cmd_o.latch2 = 1'b1;
        st_d = lsod_pkg::ST_WR;
      end
      lsod_pkg::ST_WR: begin
        cmd_o.wr = 1'b1;
        st_d = lsod_pkg::ST_F0;
        if (ent_q == 7'(lsod_pkg::PlaneLen - 1)) begin
          ent_d  = '0;
          seg_d  = '0;
          segi_d = '0;
          row_d  = '0;
          col_d  = '0;
          if (plane_q == 2'd2) begin
            st_d = lsod_pkg::ST_FIN;
          end else begin
            plane_d = plane_q + 2'd1;
          end
        end else begin
          ent_d = ent_q + 7'd1;
          if (segi_inc == lsod_pkg::seg_len(stat_i.luma_lay1, seg_q)) begin
            seg_d  = seg_q + 5'd1;
            segi_d = '0;
          end else begin
            segi_d = segi_inc;
          end
          if (col_q == col_last) begin
            col_d = '0;
            row_d = row_q + 4'd1;
          end else begin
            col_d = col_q + 4'd1;
          end
        end
      end
      lsod_pkg::ST_FIN: begin
        cmd_o.fin = 1'b1;
        st_d = lsod_pkg::ST_IDLE;
      end
      lsod_pkg::ST_RD: begin
        cmd_o.out_rd = 1'b1;
        st_d = lsod_pkg::ST_IDLE;
      end
      default: st_d = lsod_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= lsod_pkg::ST_IDLE;
      sweep_q <= '0;
      plane_q <= '0;
      ent_q   <= '0;
      seg_q   <= '0;
      segi_q  <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      st_q    <= st_d;
      sweep_q <= sweep_d;
      plane_q <= plane_d;
      ent_q   <= ent_d;
      seg_q   <= seg_d;
      segi_q  <= segi_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  // The sweep never runs past the last stored byte.
  a_sweep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == lsod_pkg::ST_SWEEP |-> sweep_q <= 8'(lsod_pkg::AddrXorChk))
    else $error("sweep address out of range");

  // The walk finishes only after the last entry of the last plane.
  a_fin_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == lsod_pkg::ST_FIN |-> $past(plane_q) == 2'd2 && $past(st_q) == lsod_pkg::ST_WR)
    else $error("decode finished early");

endmodule

### src/lsod_dp.sv
// ----------------------------------------------------------------------------
// Lens-shading OTP decoder datapath
// Raw and table stores, field extraction, checksums and output register.
// ----------------------------------------------------------------------------
module lsod_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsod_pkg::ctrl_cmd_t cmd_i,
  input  lsod_pkg::in_t       in_data_i,
  input  logic                out_stall_i,
  output lsod_pkg::dp_stat_t  stat_o,
  output logic                out_valid_o,
  output lsod_pkg::out_t      out_data_o
);

  logic [7:0] raw_mem [0:lsod_pkg::RawDepth-1];
  logic [7:0] tbl_mem [0:lsod_pkg::TblDepth-1];
  logic [7:0] rdata_q, tbl_rdata_q;
  logic       oob_q;
  logic       sweep_vld_q;
  logic [7:0] sweep_addr_q;
  logic [7:0] lo_ofs_q, lo_hdr_q, c1_ofs_q, c1_hdr_q, c2_ofs_q, c2_hdr_q;
  logic [7:0] chk_raw_q, chk_tbl_q, chk_xor_q;
  logic [7:0] raw_acc_q, tbl_acc_q;
  logic [7:0] b0_q, b1_q, b2_q;
  logic [2:0] flags_q, flags_d;
  logic       out_valid_q, out_valid_d;
  lsod_pkg::out_t out_q, out_d;

  logic       wide, six, shl, is_luma;
  logic [6:0] fidx;
  logic [4:0] base_n;
  logic [7:0] pbase, c_ofs, c_hdr;
  logic [10:0] bit_ofs;
  logic [7:0] a0, a1, a2, rd_addr;
  logic [15:0] win;
  logic [4:0] f5;
  logic [5:0] f6;
  logic [1:0] dlt;
  logic [7:0] luma_raw, luma_v, chroma_v, val;
  logic [15:0] luma_sh;
  logic [3:0] lsh;
  logic [8:0] tbl_idx;
  logic [7:0] cr, ct;
  logic       m_raw, m_tbl;

  assign is_luma = (cmd_i.plane == 2'd0);
  assign wide    = lo_hdr_q[7:4] > 4'(lsod_pkg::NarrowMax);
  assign fidx    = wide ? cmd_i.lj : cmd_i.ent;
  assign six     = wide && (cmd_i.lj >= 7'(lsod_pkg::LumaSplit));
  assign shl     = wide && (cmd_i.lj >= 7'(lsod_pkg::LumaShift));
  assign pbase   = (cmd_i.plane == 2'd1) ? 8'(lsod_pkg::Chroma1Ofs) : 8'(lsod_pkg::Chroma2Ofs);
  assign c_ofs   = (cmd_i.plane == 2'd1) ? c1_ofs_q : c2_ofs_q;
  assign c_hdr   = (cmd_i.plane == 2'd1) ? c1_hdr_q : c2_hdr_q;
  assign base_n  = 5'(cmd_i.row[3:1]) * (c_hdr[6] ? 5'd5 : 5'd6) + 5'(cmd_i.col[3:1]);

  always_comb begin
    if (!is_luma) begin
      bit_ofs = {pbase, 3'b000} + 11'd10 + 11'(base_n) * 11'd5;
    end else if (six) begin
      bit_ofs = 11'd256 + 11'(fidx - 7'(lsod_pkg::LumaSplit)) * 11'd6;
    end else begin
      bit_ofs = 11'd16 + 11'(fidx) * 11'd5;
    end
  end

  assign a0 = bit_ofs[10:3];
  assign a1 = a0 + 8'd1;
  assign a2 = is_luma ? a0 : pbase + 8'(lsod_pkg::DeltaOfs) + 8'(cmd_i.ent[6:2]);

  always_comb begin
    case (cmd_i.fetch_sel)
      2'd0:    rd_addr = a0;
      2'd1:    rd_addr = a1;
      default: rd_addr = a2;
    endcase
    if (cmd_i.sweep_rd) begin
      rd_addr = cmd_i.sweep_addr;
    end
  end

  // Field extraction from the two fetched bytes and the delta byte, MSB first.
  assign win = {b0_q, b1_q};
  assign f5  = 5'(win >> (4'd11 - {1'b0, bit_ofs[2:0]}));
  assign f6  = 6'(win >> (4'd10 - {1'b0, bit_ofs[2:0]}));
  assign dlt = 2'(b2_q >> (3'd6 - {cmd_i.ent[1:0], 1'b0}));

  assign luma_raw = six ? {2'b00, f6} : {3'b000, f5};
  assign lsh      = lo_hdr_q[7:4] - 4'd6;
  assign luma_sh  = {8'h00, luma_raw} << lsh;
  assign luma_v   = (shl ? luma_sh[7:0] : luma_raw) + lo_ofs_q;
  assign chroma_v = ((8'(f5) + 8'(dlt)) << c_hdr[7]) + c_ofs;
  assign val      = is_luma ? luma_v : chroma_v;
  assign tbl_idx  = 9'(cmd_i.plane) * 9'(lsod_pkg::PlaneLen) + 9'(cmd_i.ent);

  assign cr    = raw_acc_q + 8'd1;
  assign ct    = tbl_acc_q + 8'd1;
  assign m_raw = (cr == chk_raw_q);
  assign m_tbl = (ct == chk_tbl_q);

  // Raw store: loads from the input, reads by sweep or fetch.
  always_ff @(posedge clk_i) begin
    if (cmd_i.raw_wr && (in_data_i.index < 9'(lsod_pkg::RawDepth))) begin
      raw_mem[in_data_i.index[7:0]] <= in_data_i.raw_byte;
    end
    if (cmd_i.sweep_rd || cmd_i.fetch_rd) begin
      rdata_q <= raw_mem[rd_addr];
    end
  end

  // Table store: written by the walk, read by the read command.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      tbl_mem[tbl_idx] <= val;
    end
    if (cmd_i.tbl_rd) begin
      oob_q <= in_data_i.index >= 9'(lsod_pkg::TblDepth);
      if (in_data_i.index < 9'(lsod_pkg::TblDepth)) begin
        tbl_rdata_q <= tbl_mem[in_data_i.index];
      end
    end
  end

  // Header capture, checksum accumulation and fetched bytes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      raw_acc_q <= '0;
      tbl_acc_q <= '0;
    end
    if (sweep_vld_q) begin
      if (sweep_addr_q <= 8'(lsod_pkg::RawSumLast)) begin
        raw_acc_q <= lsod_pkg::mod255_add(raw_acc_q, rdata_q);
      end
      case (sweep_addr_q)
        8'd0:                          lo_ofs_q  <= rdata_q;
        8'd1:                          lo_hdr_q  <= rdata_q;
        8'(lsod_pkg::Chroma1Ofs):      c1_ofs_q  <= rdata_q;
        8'(lsod_pkg::Chroma1Ofs + 1):  c1_hdr_q  <= rdata_q;
        8'(lsod_pkg::Chroma2Ofs):      c2_ofs_q  <= rdata_q;
        8'(lsod_pkg::Chroma2Ofs + 1):  c2_hdr_q  <= rdata_q;
        8'(lsod_pkg::AddrRawChk):      chk_raw_q <= rdata_q;
        8'(lsod_pkg::AddrTblChk):      chk_tbl_q <= rdata_q;
        8'(lsod_pkg::AddrXorChk):      chk_xor_q <= rdata_q;
        default: ;
      endcase
    end
    if (cmd_i.wr) begin
      tbl_acc_q <= lsod_pkg::mod255_add(tbl_acc_q, val);
    end
    if (cmd_i.latch0) b0_q <= rdata_q;
    if (cmd_i.latch1) b1_q <= rdata_q;
    if (cmd_i.latch2) b2_q <= rdata_q;
    sweep_addr_q <= cmd_i.sweep_addr;
  end

  always_comb begin
    flags_d     = flags_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.fin) begin
      flags_d = {(m_raw && m_tbl) || ((cr ^ ct) == chk_xor_q), m_tbl, m_raw};
      out_d.entry_value = '0;
      out_valid_d = 1'b1;
    end else if (cmd_i.out_rd) begin
      out_d.entry_value = oob_q ? 8'h00 : tbl_rdata_q;
      out_valid_d = 1'b1;
    end
    out_d.raw_sum_match   = flags_d[0];
    out_d.table_sum_match = flags_d[1];
    out_d.table_valid     = flags_d[2];
    if (!(cmd_i.fin || cmd_i.out_rd)) begin
      out_d = out_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      out_valid_q <= 1'b0;
      sweep_vld_q <= 1'b0;
    end else begin
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
      sweep_vld_q <= cmd_i.sweep_rd;
    end
  end

  assign stat_o.luma_lay1   = (lo_hdr_q[3:0] != 4'h0);
  assign stat_o.chroma_lay1 = c_hdr[6];
  assign stat_o.out_valid   = out_valid_q;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

  // A result appears only after a finished decode or a table read.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !$past(out_valid_q) |-> $past(cmd_i.fin) || $past(cmd_i.out_rd))
    else $error("result without a source");

  // Table writes stay inside the table.
  a_tbl_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr |-> tbl_idx < 9'(lsod_pkg::TblDepth))
    else $error("table write out of range");

  // A finished decode or a table read never loads a result while one is still held.
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin || cmd_i.out_rd |-> !out_valid_q)
    else $error("output register overwritten");

endmodule

### src/lens_shading_otp_decoder_core.sv
// ----------------------------------------------------------------------------
// Lens-shading OTP decoder core
// Sequence: a load writes the raw store and gives no result; a read goes
// through the table read register, then the output register; a decode sweeps
// every raw byte, takes each of the 360 table entries through states F0 to
// F3 and WR on the single raw read port, then the FIN state loads the flags.
// Throughput: one load per cycle unless stalled; reads/decodes one at a time.
// Reset: asynchronous, clears the sequencer, output valid and check flags;
// the raw and table stores hold no defined value until written.
// ----------------------------------------------------------------------------
module lens_shading_otp_decoder_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  lsod_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lsod_pkg::out_t  out_data_o
);

  // The controller walks a decode request in three phases. First it sweeps
  // every raw byte once, which builds the raw checksum and captures the
  // headers. Then it visits each of the 360 table entries in order, fetching
  // the two bytes that hold the entry's packed field and the delta byte for
  // colour planes. Finally it compares the sums and loads the result.
  lsod_pkg::ctrl_cmd_t cmd;
  lsod_pkg::dp_stat_t  stat;

  lsod_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_cmd_i    (in_data_i.cmd),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds both stores, the extraction logic, the running sums
  // modulo 255 and the output register that holds a result until taken.
  lsod_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
